>>> hw/rtl/positional_audio_gain_pan_unit_assert.svh
// Assertion macros for the positional gain and pan unit.
// Used by the checker; expects clk and arst_n in scope.
`ifndef POSITIONAL_AUDIO_GAIN_PAN_UNIT_ASSERT_SVH
`define POSITIONAL_AUDIO_GAIN_PAN_UNIT_ASSERT_SVH

// clocked assertion, disabled during reset
`define PAGP_ASSERT_CLK(label, ck, rst_n, prop) \
	label: assert property (@(posedge ck) disable iff (!rst_n) prop) \
		else $error("pagp assertion failed");

// same, on the default clock and reset names
`define PAGP_ASSERT(label, prop) \
	`PAGP_ASSERT_CLK(label, clk, arst_n, prop)

`endif

>>> hw/rtl/pagp_pkg.sv
// Shared constants, types and tables of the positional gain and pan unit.
// No dependencies.
package pagp_pkg;

	localparam int CHANNEL_COUNT = 32;
	localparam int CH_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
	localparam logic [8:0] UNSET_VAL = 9'h1FF;
	localparam logic [7:0] FULL_VOL = 8'd128;
	localparam logic [7:0] CENTER_PAN = 8'd127;
	localparam int CORDIC_STEPS = 20;
	localparam int STEP_W = 5;
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);
	localparam int NUM_W = 48;
	localparam int DEN_W = 40;
	localparam logic [23:0] SCALE_RECIP = 24'd8454531;
	localparam int SCALE_SHIFT = 39;
	localparam logic [11:0] PAN_NUM_K = 12'd2559;

	typedef enum logic [1:0] {
		REG_MASTER_VOLUME = 2'd0,
		REG_MAX_RADIUS    = 2'd1,
		REG_STEREO_ENABLE = 2'd2
	} reg_idx_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_SQX,
		OP_SQY,
		OP_SQZ,
		OP_PREP,
		OP_MLO,
		OP_MHI,
		OP_SQRT,
		OP_DIV_ATT,
		OP_ATT_TAKE,
		OP_NORM_INIT,
		OP_NORM_STEP,
		OP_QUAD,
		OP_CORDIC,
		OP_PSQX,
		OP_PSQY,
		OP_DIV_PAN,
		OP_PAN_TAKE,
		OP_SCL_MUL,
		OP_SCL_TAKE,
		OP_EMIT
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [STEP_W-1:0] step;
	} cmd_t;

	typedef struct packed {
		logic has_loc;
		logic att_go;
		logic pan_go;
		logic norm_done;
		logic m_zero;
		logic sqrt_busy;
		logic div_busy;
		logic out_free;
	} stat_t;

	function automatic logic [29:0] atan_turn(input logic [STEP_W-1:0] i);
		logic [29:0] v;
		case (i)
			5'd0:    v = 30'h20000000;
			5'd1:    v = 30'h12E4051E;
			5'd2:    v = 30'h09FB385B;
			5'd3:    v = 30'h051111D4;
			5'd4:    v = 30'h028B0D43;
			5'd5:    v = 30'h0145D7E1;
			5'd6:    v = 30'h00A2F61E;
			5'd7:    v = 30'h00517C55;
			5'd8:    v = 30'h0028BE53;
			5'd9:    v = 30'h00145F2F;
			5'd10:   v = 30'h000A2F98;
			5'd11:   v = 30'h000517CC;
			5'd12:   v = 30'h00028BE6;
			5'd13:   v = 30'h000145F3;
			5'd14:   v = 30'h0000A2FA;
			5'd15:   v = 30'h0000517D;
			5'd16:   v = 30'h000028BE;
			5'd17:   v = 30'h0000145F;
			5'd18:   v = 30'h00000A30;
			5'd19:   v = 30'h00000518;
			default: v = 30'h0;
		endcase
		return v;
	endfunction

endpackage

>>> hw/rtl/pagp_if.sv
// Channel interfaces of the positional gain and pan unit: item, result, config.
// No dependencies.
interface pagp_item_if;
	logic               valid;
	logic               ready;
	logic [4:0]         channel;
	logic               restart;
	logic               has_location;
	logic signed [23:0] offset_x;
	logic signed [23:0] offset_y;
	logic signed [23:0] offset_z;
	logic [15:0]        listener_yaw;
	logic               from_entity;
	logic [15:0]        radius;
	logic [15:0]        inner_radius;
	logic [7:0]         source_volume;

	modport source (output valid, channel, restart, has_location, offset_x, offset_y,
		offset_z, listener_yaw, from_entity, radius, inner_radius, source_volume,
		input ready);
	modport sink (input valid, channel, restart, has_location, offset_x, offset_y,
		offset_z, listener_yaw, from_entity, radius, inner_radius, source_volume,
		output ready);
endinterface

interface pagp_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] volume;
	logic [7:0] pan;
	logic       changed;

	modport source (output valid, volume, pan, changed, input ready);
	modport sink (input valid, volume, pan, changed, output ready);
endinterface

interface pagp_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [13:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/pagp_isqrt.sv
// Iterative integer square root, one result bit per cycle.
// No package dependencies.
module pagp_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] radicand,
	output logic [31:0] root,
	output logic        busy
);

	logic [63:0] n_q;
	logic [63:0] r_q;
	logic [4:0]  k_q;
	logic        busy_q;
	logic [63:0] bit_c;
	logic [64:0] sum_c;
	logic        take_c;

	assign bit_c  = 64'd1 << {k_q, 1'b0};
	assign sum_c  = {1'b0, r_q} + {1'b0, bit_c};
	assign take_c = {1'b0, n_q} >= sum_c;
	assign root   = r_q[31:0];
	assign busy   = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q    <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			k_q    <= 5'd31;
		end else if (busy_q) begin
			if (k_q == 5'd0) begin
				busy_q <= 1'b0;
			end else begin
				k_q <= k_q - 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= radicand;
			r_q <= '0;
		end else if (busy_q) begin
			if (take_c) begin
				n_q <= n_q - sum_c[63:0];
				r_q <= (r_q >> 1) + bit_c;
			end else begin
				r_q <= r_q >> 1;
			end
		end
	end

endmodule

>>> hw/rtl/pagp_div.sv
// Restoring divider with an 8-bit saturating quotient, one bit per cycle.
// Depends on pagp_pkg for operand widths.
module pagp_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [pagp_pkg::NUM_W-1:0] num,
	input  logic [pagp_pkg::DEN_W-1:0] den,
	output logic [7:0]                 quo,
	output logic                       busy
);
	import pagp_pkg::*;

	logic [NUM_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [7:0]       q_q;
	logic             sat_q;
	logic [3:0]       cnt_q;
	logic             busy_q;
	logic [NUM_W:0]   trial_c;
	logic             ge_c;

	assign trial_c = {{(NUM_W + 1 - DEN_W){1'b0}}, den_q} << cnt_q;
	assign ge_c    = {1'b0, rem_q} >= trial_c;
	assign quo     = sat_q ? 8'hFF : q_q;
	assign busy    = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 4'd8;
		end else if (busy_q) begin
			if (cnt_q == 4'd0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			q_q   <= '0;
			sat_q <= 1'b0;
		end else if (busy_q) begin
			if (cnt_q == 4'd8) begin
				sat_q <= ge_c;
			end else if (ge_c) begin
				rem_q           <= rem_q - trial_c[NUM_W-1:0];
				q_q[cnt_q[2:0]] <= 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/pagp_ctrl.sv
// Controller state machine: sequences the datapath one item at a time.
// Depends on pagp_pkg for command and status types.
module pagp_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  pagp_pkg::stat_t stat,
	output pagp_pkg::cmd_t  cmd
);
	import pagp_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_SQX, S_SQY, S_SQZ, S_PREP, S_MLO, S_MHI, S_SQA, S_WSQA,
		S_ACHK, S_WDA, S_ATAKE, S_PCHK, S_NORM, S_QUAD, S_CORD, S_PSQX,
		S_PSQY, S_SQP, S_WSQP, S_MCHK, S_WDP, S_PTAKE, S_SCL,
		S_STAKE, S_EMIT
	} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] cnt_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd.op   = OP_NONE;
		cmd.step = cnt_q;
		case (state_q)
			S_IDLE:  if (in_valid) cmd.op = OP_LOAD;
			S_SQX:   cmd.op = OP_SQX;
			S_SQY:   cmd.op = OP_SQY;
			S_SQZ:   cmd.op = OP_SQZ;
			S_PREP:  cmd.op = OP_PREP;
			S_MLO:   cmd.op = OP_MLO;
			S_MHI:   cmd.op = OP_MHI;
			S_SQA:   cmd.op = OP_SQRT;
			S_ACHK:  if (stat.att_go) cmd.op = OP_DIV_ATT;
			S_ATAKE: cmd.op = OP_ATT_TAKE;
			S_PCHK:  if (stat.pan_go) cmd.op = OP_NORM_INIT;
			S_NORM:  if (!stat.norm_done) cmd.op = OP_NORM_STEP;
			S_QUAD:  cmd.op = OP_QUAD;
			S_CORD:  cmd.op = OP_CORDIC;
			S_PSQX:  cmd.op = OP_PSQX;
			S_PSQY:  cmd.op = OP_PSQY;
			S_SQP:   cmd.op = OP_SQRT;
			S_MCHK:  if (!stat.m_zero) cmd.op = OP_DIV_PAN;
			S_PTAKE: cmd.op = OP_PAN_TAKE;
			S_SCL:   cmd.op = OP_SCL_MUL;
			S_STAKE: cmd.op = OP_SCL_TAKE;
			S_EMIT:  if (stat.out_free) cmd.op = OP_EMIT;
			default: cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE:  if (in_valid) state_q <= S_SQX;
				S_SQX:   state_q <= stat.has_loc ? S_SQY : S_SCL;
				S_SQY:   state_q <= S_SQZ;
				S_SQZ:   state_q <= S_PREP;
				S_PREP:  state_q <= S_MLO;
				S_MLO:   state_q <= S_MHI;
				S_MHI:   state_q <= S_SQA;
				S_SQA:   state_q <= S_WSQA;
				S_WSQA:  if (!stat.sqrt_busy) state_q <= S_ACHK;
				S_ACHK:  state_q <= stat.att_go ? S_WDA : S_PCHK;
				S_WDA:   if (!stat.div_busy) state_q <= S_ATAKE;
				S_ATAKE: state_q <= S_PCHK;
				S_PCHK:  state_q <= stat.pan_go ? S_NORM : S_SCL;
				S_NORM:  if (stat.norm_done) state_q <= S_QUAD;
				S_QUAD: begin
					state_q <= S_CORD;
					cnt_q   <= '0;
				end
				S_CORD: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_STEP) state_q <= S_PSQX;
				end
				S_PSQX:  state_q <= S_PSQY;
				S_PSQY:  state_q <= S_SQP;
				S_SQP:   state_q <= S_WSQP;
				S_WSQP:  if (!stat.sqrt_busy) state_q <= S_MCHK;
				S_MCHK:  state_q <= stat.m_zero ? S_SCL : S_WDP;
				S_WDP:   if (!stat.div_busy) state_q <= S_PTAKE;
				S_PTAKE: state_q <= S_SCL;
				S_SCL:   state_q <= S_STAKE;
				S_STAKE: state_q <= S_EMIT;
				S_EMIT:  if (stat.out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> hw/rtl/pagp_dp.sv
// Datapath: config registers, item registers, squares, CORDIC, shared root
// and divide units, per-channel store and result register. Uses pagp_pkg.
module pagp_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  pagp_pkg::cmd_t     cmd,
	output pagp_pkg::stat_t    stat,
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [13:0]        cfg_data,
	input  logic [4:0]         channel,
	input  logic               restart,
	input  logic               has_location,
	input  logic signed [23:0] offset_x,
	input  logic signed [23:0] offset_y,
	input  logic signed [23:0] offset_z,
	input  logic [15:0]        listener_yaw,
	input  logic               from_entity,
	input  logic [15:0]        radius,
	input  logic [15:0]        inner_radius,
	input  logic [7:0]         source_volume,
	output logic               res_valid,
	input  logic               res_ready,
	output logic [7:0]         volume,
	output logic [7:0]         pan,
	output logic               changed
);
	import pagp_pkg::*;

	logic [7:0]         mv_q;
	logic [13:0]        maxr_q;
	logic               stereo_q;
	logic [4:0]         ch_q;
	logic               restart_q;
	logic               loc_q;
	logic signed [23:0] x_q, y_q, z_q;
	logic [15:0]        yaw_q;
	logic               ent_q;
	logic [15:0]        radius_q, inner_q;
	logic [7:0]         svol_q;
	logic [47:0]        s_q;
	logic [63:0]        sq_q;
	logic [15:0]        mv2_q;
	logic [39:0]        ie16sq_q;
	logic [23:0]        mvie_q;
	logic signed [16:0] rad_q;
	logic [7:0]         vol_q, pan_q;
	logic signed [33:0] px_q, py_q;
	logic signed [32:0] ang_q;
	logic [46:0]        scl_prod_q;
	logic               res_valid_q;
	logic [7:0]         res_vol_q, res_pan_q;
	logic               res_chg_q;
	logic [8:0]         last_vol_q [CHANNEL_COUNT];
	logic [8:0]         last_pan_q [CHANNEL_COUNT];

	logic signed [47:0] xsq_c, ysq_c, zsq_c;
	logic [15:0]        ie_c;
	logic [19:0]        ie16_c;
	logic signed [16:0] rad_c;
	logic [31:0]        root_c;
	logic               sqrt_busy_c;
	logic [7:0]         quo_c;
	logic               div_busy_c;
	logic               div_start_c;
	logic [NUM_W-1:0]   div_num_c;
	logic [DEN_W-1:0]   div_den_c;
	logic signed [28:0] nval_c;
	logic [33:0]        pxa_c, pya_c;
	logic signed [33:0] dx_c, dy_c;
	logic [15:0]        ang_a_c;
	logic signed [34:0] diff_c;
	logic [45:0]        pnum_c;
	logic [36:0]        pden_c;
	logic [22:0]        snum_c;
	logic [7:0]         scl_c;
	logic [7:0]         att_c;
	logic               in_range_c;
	logic [CH_W-1:0]    idx_c;
	logic               chg_c;

	assign xsq_c  = x_q * x_q;
	assign ysq_c  = y_q * y_q;
	assign zsq_c  = z_q * z_q;
	assign ie_c   = ent_q ? inner_q : 16'd0;
	assign ie16_c = {ie_c, 4'b0};

	always_comb begin
		if (ent_q) begin
			rad_c = $signed({1'b0, radius_q}) - $signed({1'b0, inner_q});
		end else if (radius_q != 16'd0) begin
			if (maxr_q != 14'd0 && {2'b0, maxr_q} < radius_q) begin
				rad_c = $signed({3'b0, maxr_q});
			end else begin
				rad_c = $signed({1'b0, radius_q});
			end
		end else begin
			rad_c = $signed({3'b0, maxr_q});
		end
	end

	assign nval_c  = $signed({1'b0, root_c[31:4]}) - $signed({5'b0, mvie_q});
	assign pxa_c   = px_q[33] ? 34'(-px_q) : 34'(px_q);
	assign pya_c   = py_q[33] ? 34'(-py_q) : 34'(py_q);
	assign dx_c    = py_q >>> cmd.step;
	assign dy_c    = px_q >>> cmd.step;
	assign ang_a_c = 16'd0 - yaw_q;
	assign diff_c  = $signed({3'b0, root_c}) - $signed({px_q[33], px_q});
	assign pnum_c  = PAN_NUM_K * diff_c[33:0];
	assign pden_c  = {1'b0, root_c, 4'b0} + {3'b0, root_c, 2'b0};
	assign snum_c  = {{8'b0, vol_q} * {8'b0, svol_q}, 7'b0};
	assign scl_c   = scl_prod_q[SCALE_SHIFT +: 8];
	assign att_c   = (quo_c < mv_q) ? quo_c : mv_q;

	always_comb begin
		div_start_c = 1'b0;
		div_num_c   = '0;
		div_den_c   = '0;
		case (cmd.op)
			OP_DIV_ATT: begin
				div_start_c = 1'b1;
				div_num_c   = {{(NUM_W - 28){1'b0}}, nval_c[27:0]};
				div_den_c   = {{(DEN_W - 16){1'b0}}, rad_q[15:0]};
			end
			OP_DIV_PAN: begin
				div_start_c = 1'b1;
				div_num_c   = {{(NUM_W - 46){1'b0}}, pnum_c};
				div_den_c   = {{(DEN_W - 37){1'b0}}, pden_c};
			end
			default:    div_start_c = 1'b0;
		endcase
	end

	pagp_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.op == OP_SQRT),
		.radicand (sq_q),
		.root     (root_c),
		.busy     (sqrt_busy_c)
	);

	pagp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_c),
		.num    (div_num_c),
		.den    (div_den_c),
		.quo    (quo_c),
		.busy   (div_busy_c)
	);

	assign stat.has_loc   = loc_q;
	assign stat.att_go    = (rad_q > 17'sd0) && (mv_q != 8'd0) && !nval_c[28];
	assign stat.pan_go    = stereo_q && (x_q != 24'sd0 || y_q != 24'sd0) &&
		(s_q > {8'b0, ie16sq_q});
	assign stat.norm_done = (pxa_c[33:28] != 6'd0) || (pya_c[33:28] != 6'd0);
	assign stat.m_zero    = (root_c == 32'd0);
	assign stat.sqrt_busy = sqrt_busy_c;
	assign stat.div_busy  = div_busy_c;
	assign stat.out_free  = !res_valid_q || res_ready;

	assign in_range_c = (32'(ch_q) < CHANNEL_COUNT);
	assign idx_c      = CH_W'(ch_q);
	assign chg_c      = restart_q || !in_range_c || (last_vol_q[idx_c] != {1'b0, vol_q}) ||
		(last_pan_q[idx_c] != {1'b0, pan_q});

	assign res_valid = res_valid_q;
	assign volume    = res_vol_q;
	assign pan       = res_pan_q;
	assign changed   = res_chg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_q        <= 8'd255;
			maxr_q      <= 14'd340;
			stereo_q    <= 1'b1;
			res_valid_q <= 1'b0;
			for (int i = 0; i < CHANNEL_COUNT; i++) begin
				last_vol_q[i] <= UNSET_VAL;
				last_pan_q[i] <= UNSET_VAL;
			end
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_MASTER_VOLUME: mv_q     <= cfg_data[7:0];
					REG_MAX_RADIUS:    maxr_q   <= cfg_data;
					REG_STEREO_ENABLE: stereo_q <= cfg_data[0];
					default:           mv_q     <= mv_q;
				endcase
			end
			if (cmd.op == OP_EMIT) begin
				res_valid_q <= 1'b1;
				if (in_range_c) begin
					last_vol_q[idx_c] <= {1'b0, vol_q};
					last_pan_q[idx_c] <= {1'b0, pan_q};
				end
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				ch_q      <= channel;
				restart_q <= restart;
				loc_q     <= has_location;
				x_q       <= offset_x;
				y_q       <= offset_y;
				z_q       <= offset_z;
				yaw_q     <= listener_yaw;
				ent_q     <= from_entity;
				radius_q  <= radius;
				inner_q   <= inner_radius;
				svol_q    <= source_volume;
				vol_q     <= mv_q;
				pan_q     <= CENTER_PAN;
				mv2_q     <= mv_q * mv_q;
			end
			OP_SQX: s_q <= xsq_c;
			OP_SQY: s_q <= s_q + ysq_c;
			OP_SQZ: s_q <= s_q + zsq_c;
			OP_PREP: begin
				ie16sq_q <= ie16_c * ie16_c;
				mvie_q   <= mv_q * ie_c;
				rad_q    <= rad_c;
			end
			OP_MLO: sq_q <= {24'b0, 40'(mv2_q) * 40'(s_q[23:0])};
			OP_MHI: sq_q <= sq_q + {40'(mv2_q) * 40'(s_q[47:24]), 24'b0};
			OP_ATT_TAKE: vol_q <= mv_q - att_c;
			OP_NORM_INIT: begin
				px_q <= 34'(x_q);
				py_q <= 34'(y_q);
			end
			OP_NORM_STEP: begin
				px_q <= px_q <<< 1;
				py_q <= py_q <<< 1;
			end
			OP_QUAD: begin
				ang_q <= $signed({3'b0, ang_a_c[13:0], 16'b0});
				case (ang_a_c[15:14])
					2'd1: begin
						px_q <= -py_q;
						py_q <= px_q;
					end
					2'd2: begin
						px_q <= -px_q;
						py_q <= -py_q;
					end
					2'd3: begin
						px_q <= py_q;
						py_q <= -px_q;
					end
					default: px_q <= px_q;
				endcase
			end
			OP_CORDIC: begin
				if (!ang_q[32]) begin
					px_q  <= px_q - dx_c;
					py_q  <= py_q + dy_c;
					ang_q <= ang_q - $signed({3'b0, atan_turn(cmd.step)});
				end else begin
					px_q  <= px_q + dx_c;
					py_q  <= py_q - dy_c;
					ang_q <= ang_q + $signed({3'b0, atan_turn(cmd.step)});
				end
			end
			OP_PSQX: sq_q <= pxa_c[31:0] * pxa_c[31:0];
			OP_PSQY: sq_q <= sq_q + pya_c[31:0] * pya_c[31:0];
			OP_PAN_TAKE: pan_q <= quo_c;
			OP_SCL_MUL: scl_prod_q <= snum_c * SCALE_RECIP;
			OP_SCL_TAKE: vol_q <= (scl_c > FULL_VOL) ? FULL_VOL : scl_c;
			OP_EMIT: begin
				res_vol_q <= vol_q;
				res_pan_q <= pan_q;
				res_chg_q <= chg_c;
			end
			default: vol_q <= vol_q;
		endcase
	end

endmodule

>>> hw/rtl/positional_audio_gain_pan_unit.sv
// Positional gain and pan unit: one item at a time. A result takes longer with a location
// than without one and longer again when pan is computed, set by the bit-serial root,
// the divider, the normalize steps and 20 CORDIC steps; the next input transfer can follow
// once the result is registered. The result register frees the input while a result waits.
// Reset is asynchronous: config returns to its defaults and every stored channel volume
// and pan to unset.
module positional_audio_gain_pan_unit (
	input logic          clk,
	input logic          arst_n,
	pagp_item_if.sink    item,
	pagp_result_if.source result,
	pagp_cfg_if.sink     cfg
);
	import pagp_pkg::*;

	cmd_t  cmd;
	stat_t stat;
	logic  in_ready;

	assign item.ready = in_ready;
	assign cfg.ready  = 1'b1;

	pagp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	pagp_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_write     (cfg.valid),
		.cfg_index     (cfg.index),
		.cfg_data      (cfg.data),
		.channel       (item.channel),
		.restart       (item.restart),
		.has_location  (item.has_location),
		.offset_x      (item.offset_x),
		.offset_y      (item.offset_y),
		.offset_z      (item.offset_z),
		.listener_yaw  (item.listener_yaw),
		.from_entity   (item.from_entity),
		.radius        (item.radius),
		.inner_radius  (item.inner_radius),
		.source_volume (item.source_volume),
		.res_valid     (result.valid),
		.res_ready     (result.ready),
		.volume        (result.volume),
		.pan           (result.pan),
		.changed       (result.changed)
	);

endmodule

>>> hw/rtl/pagp_chk.sv
// Port-level checker for the positional gain and pan unit, bound to the top.
// Depends on positional_audio_gain_pan_unit_assert.svh.
`include "positional_audio_gain_pan_unit_assert.svh"

module pagp_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_volume,
	input logic [7:0] out_pan,
	input logic       cfg_ready
);

	`PAGP_ASSERT(a_vol_cap, out_valid |-> (out_volume <= 8'd128))
	`PAGP_ASSERT(a_busy_after_transfer, (in_valid && in_ready) |=> !in_ready)
	`PAGP_ASSERT(a_cfg_ready, cfg_ready)
	`PAGP_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_volume) && $stable(out_pan)))

endmodule

bind positional_audio_gain_pan_unit pagp_chk u_pagp_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (item.valid),
	.in_ready   (item.ready),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.out_volume (result.volume),
	.out_pan    (result.pan),
	.cfg_ready  (cfg.ready)
);
